// ===== design/wwcc_pkg.sv =====
package wwcc_pkg;

	// configuration port
	localparam int ADDR_W = 4;
	localparam int DATA_W = 64;
	localparam int REG_SEL_BIT = 3;

	// register codes, selected by paddr[REG_SEL_BIT]
	localparam logic REG_TOTAL_LENGTH = 1'b0;
	localparam logic REG_EXPECTED_HASH = 1'b1;

	localparam logic [31:0] TOTAL_LENGTH_RST = 32'd1;
	localparam logic [63:0] EXPECTED_HASH_RST = 64'd0;

	// full words counted per payload
	localparam int IDX_W = 30;

	typedef struct packed {
		logic [31:0] data_word;
		logic [2:0]  byte_count;
		logic        last;
	} in_t;

	typedef struct packed {
		logic [63:0] hash_value;
		logic        match;
		logic        length_error;
	} out_t;

	// classified word, handed from the front end to the back end
	typedef struct packed {
		logic [31:0]      data_word;
		logic             full_word;
		logic [1:0]       tail_count;
		logic             last;
		logic [IDX_W-1:0] word_index;
		logic [31:0]      seen;
		logic             fault;
	} mid_t;

endpackage

// ===== design/wwcc_fifo.sv =====
module wwcc_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	input  logic [WIDTH-1:0]             push_data,
	input  logic                         pop,
	output logic [WIDTH-1:0]             pop_data,
	output logic                         full,
	output logic                         empty,
	output logic [$clog2(DEPTH+1)-1:0]   level
);

	localparam int PW = $clog2(DEPTH);
	localparam int LW = $clog2(DEPTH+1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [LW-1:0]    level_q;
	logic             do_push;
	logic             do_pop;

	assign full     = (level_q == LW'(DEPTH));
	assign empty    = (level_q == '0);
	assign level    = level_q;
	assign do_push  = push & ~full;
	assign do_pop   = pop & ~empty;
	assign pop_data = mem_q[rd_ptr_q];

	// advance pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH-1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH-1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10: level_q <= level_q + 1'b1;
				2'b01: level_q <= level_q - 1'b1;
				default: level_q <= level_q;
			endcase
		end
	end

	// store the word
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

// ===== design/wwcc_front.sv =====
module wwcc_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  wwcc_pkg::in_t   in_data,
	input  logic            mid_full,
	output logic            mid_push,
	output wwcc_pkg::mid_t  mid_data
);

	import wwcc_pkg::*;

	logic [IDX_W-1:0] idx_q;
	logic             fault_q;
	logic [IDX_W-1:0] idx_inc;
	logic             idx_max;
	logic             is_full;
	logic             accept;
	logic             skip;

	assign is_full = in_data.byte_count[2];
	assign accept  = push & ~mid_full;
	// a short word before the last one only marks a fault
	assign skip    = ~in_data.last & ~is_full;
	assign idx_inc = idx_q + 1'b1;
	assign idx_max = &idx_q;

	assign mid_push = accept & ~skip;

	// classify the word and work out the byte position reached
	always_comb begin
		mid_data.data_word  = in_data.data_word;
		mid_data.full_word  = is_full;
		mid_data.tail_count = in_data.byte_count[1:0];
		mid_data.last       = in_data.last;
		mid_data.word_index = idx_q;
		mid_data.seen       = is_full ? {idx_inc, 2'b00}
			: {idx_q, 2'b00} + {30'd0, in_data.byte_count[1:0]};
		mid_data.fault      = fault_q | (is_full & idx_max);
	end

	// track word index and sequencing fault, clear after the last word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			fault_q <= 1'b0;
		end else if (accept) begin
			if (in_data.last) begin
				idx_q   <= '0;
				fault_q <= 1'b0;
			end else if (skip) begin
				fault_q <= 1'b1;
			end else begin
				idx_q <= idx_inc;
				if (idx_max) begin
					fault_q <= 1'b1;
				end
			end
		end
	end

endmodule

// ===== design/wwcc_back.sv =====
module wwcc_back #(
	parameter int OUT_DEPTH = 8
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           mid_empty,
	input  wwcc_pkg::mid_t                 mid_data,
	output logic                           mid_pop,
	input  logic [31:0]                    total_length,
	input  logic [63:0]                    expected_hash,
	input  logic [$clog2(OUT_DEPTH+1)-1:0] out_level,
	output logic                           res_push,
	output wwcc_pkg::out_t                 res_data
);

	import wwcc_pkg::*;

	localparam int LW = $clog2(OUT_DEPTH+1);
	localparam int CW = LW + 3;
	localparam logic [31:0] RECIP3 = 32'hAAAA_AAAB;

	function automatic logic [63:0] swap_halves(input logic [63:0] h);
		return {h[39:32], h[47:40], h[55:48], h[63:56],
			h[7:0], h[15:8], h[23:16], h[31:24]};
	endfunction

	logic [63:0] recip_prod;
	logic [31:0] div3_q;
	logic [31:0] div2;

	logic [32:0] op_a [3];
	logic [32:0] op_b [3];
	logic [65:0] mul  [3];

	logic [32:0] a_s1 [3];
	logic [32:0] b_s1 [3];
	logic        v_s1, l_s1, lerr_s1;
	logic [63:0] prod_s2 [3];
	logic        v_s2, l_s2, lerr_s2;
	logic [63:0] term_s3;
	logic        v_s3, l_s3, lerr_s3;
	logic [63:0] acc_q;
	logic [63:0] acc_sum;
	logic [63:0] hash_s4;
	logic        v_s4, lerr_s4;

	logic [2:0]  inflight;
	logic        room;

	// length divided by three through the reciprocal
	assign recip_prod = 64'(total_length) * 64'(RECIP3);
	assign div2       = total_length >> 1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div3_q <= '0;
		end else begin
			div3_q <= {1'b0, recip_prod[63:33]};
		end
	end

	// hold back a last word until the result queue is sure to have room
	assign inflight = 3'(v_s1 & l_s1) + 3'(v_s2 & l_s2) + 3'(v_s3 & l_s3) + 3'(v_s4);
	assign room     = (CW'(out_level) + CW'(inflight)) < CW'(OUT_DEPTH);
	assign mid_pop  = ~mid_empty & (~mid_data.last | room);

	// build the operand pairs: one lane for a full word, up to three for tail bytes
	always_comb begin
		logic [31:0] t32;
		logic [31:0] p;
		logic [31:0] tb;
		t32 = div3_q + mid_data.data_word;
		for (int k = 0; k < 3; k++) begin
			p  = {mid_data.word_index, 2'b00} + 32'(k);
			tb = div2 + {24'd0, mid_data.data_word[8*k +: 8]};
			if (mid_data.full_word) begin
				if (k == 0) begin
					op_a[k] = {1'b0, t32} + {3'd0, mid_data.word_index};
					op_b[k] = {3'd0, mid_data.word_index} + 33'd1;
				end else begin
					op_a[k] = '0;
					op_b[k] = '0;
				end
			end else if (2'(k) < mid_data.tail_count) begin
				op_a[k] = {1'b0, tb} + {1'b0, p};
				op_b[k] = {1'b0, p} + 33'd1;
			end else begin
				op_a[k] = '0;
				op_b[k] = '0;
			end
		end
	end

	// multiply the stage-one operands at full width
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			mul[k] = 66'(a_s1[k]) * 66'(b_s1[k]);
		end
	end

	// valid flags through the stages, and the running sum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_s4  <= 1'b0;
			acc_q <= '0;
		end else begin
			v_s1 <= mid_pop;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3 & l_s3;
			// accumulate, restart after the last word
			if (v_s3) begin
				acc_q <= l_s3 ? '0 : acc_sum;
			end
		end
	end

	assign acc_sum = acc_q + term_s3;

	// stage payloads
	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			a_s1[k]    <= op_a[k];
			b_s1[k]    <= op_b[k];
			prod_s2[k] <= mul[k][63:0];
		end
		l_s1    <= mid_data.last;
		lerr_s1 <= mid_data.fault | (mid_data.seen != total_length);
		l_s2    <= l_s1;
		lerr_s2 <= lerr_s1;
		term_s3 <= prod_s2[0] + prod_s2[1] + prod_s2[2];
		l_s3    <= l_s2;
		lerr_s3 <= lerr_s2;
		hash_s4 <= acc_sum;
		lerr_s4 <= lerr_s3;
	end

	// compare against the stored checksum, straight or half-swapped, and hand over the result
	assign res_push              = v_s4;
	assign res_data.hash_value   = hash_s4;
	assign res_data.match        = (hash_s4 == expected_hash)
		| (swap_halves(hash_s4) == expected_hash);
	assign res_data.length_error = lerr_s4;

endmodule

// ===== design/weighted_word_checksum_check_top.sv =====
// Channel  | Handshake                         | Payload
// input    | push / full, taken on push & !full | in_data  (data_word, byte_count, last)
// result   | empty / pop, taken on pop & !empty | out_data (hash_value, match, length_error)
// config   | APB write on psel & penable & pwrite, pready tied high | pwdata, prdata
//
// One word per cycle is taken; full rises only when the MID_DEPTH word queue between the
// front end and the multiply pipeline fills.
// A result passes through the mid queue, stages s1 to s4 and the result queue before it shows on the result ports.
// The back end holds a last word in the queue while the OUT_DEPTH result queue could
// overflow, so stalls on pop reach push only through the two queues.
// Reset clears all queues and sums, total_length to 1 and expected_hash to 0.
module weighted_word_checksum_check_top #(
	parameter int MID_DEPTH = 4,
	parameter int OUT_DEPTH = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [wwcc_pkg::ADDR_W-1:0]   paddr,
	input  logic [wwcc_pkg::DATA_W-1:0]   pwdata,
	output logic [wwcc_pkg::DATA_W-1:0]   prdata,
	output logic                          pready,
	input  logic                          push,
	output logic                          full,
	input  wwcc_pkg::in_t                 in_data,
	output logic                          empty,
	input  logic                          pop,
	output wwcc_pkg::out_t                out_data
);

	import wwcc_pkg::*;

	logic [31:0]                    total_length_q;
	logic [63:0]                    expected_hash_q;
	logic                           mid_push;
	mid_t                           mid_in;
	mid_t                           mid_head;
	logic                           mid_full;
	logic                           mid_empty;
	logic                           mid_pop;
	logic [$clog2(MID_DEPTH+1)-1:0] mid_level;
	logic                           res_push;
	out_t                           res_data;
	logic                           out_full;
	logic [$clog2(OUT_DEPTH+1)-1:0] out_level;

	assign pready = 1'b1;

	// register write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_length_q  <= TOTAL_LENGTH_RST;
			expected_hash_q <= EXPECTED_HASH_RST;
		end else if (psel && penable && pwrite) begin
			case (paddr[REG_SEL_BIT])
				REG_TOTAL_LENGTH: total_length_q <= pwdata[31:0];
				REG_EXPECTED_HASH: expected_hash_q <= pwdata;
				default: total_length_q <= total_length_q;
			endcase
		end
	end

	// register read
	always_comb begin
		case (paddr[REG_SEL_BIT])
			REG_TOTAL_LENGTH: prdata = {32'd0, total_length_q};
			REG_EXPECTED_HASH: prdata = expected_hash_q;
			default: prdata = '0;
		endcase
	end

	assign full = mid_full;

	wwcc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.in_data  (in_data),
		.mid_full (mid_full),
		.mid_push (mid_push),
		.mid_data (mid_in)
	);

	wwcc_fifo #(
		.WIDTH ($bits(mid_t)),
		.DEPTH (MID_DEPTH)
	) u_mid_q (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (mid_push),
		.push_data (mid_in),
		.pop       (mid_pop),
		.pop_data  (mid_head),
		.full      (mid_full),
		.empty     (mid_empty),
		.level     (mid_level)
	);

	wwcc_back #(
		.OUT_DEPTH (OUT_DEPTH)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.mid_empty     (mid_empty),
		.mid_data      (mid_head),
		.mid_pop       (mid_pop),
		.total_length  (total_length_q),
		.expected_hash (expected_hash_q),
		.out_level     (out_level),
		.res_push      (res_push),
		.res_data      (res_data)
	);

	wwcc_fifo #(
		.WIDTH ($bits(out_t)),
		.DEPTH (OUT_DEPTH)
	) u_out_q (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_push),
		.push_data (res_data),
		.pop       (pop),
		.pop_data  (out_data),
		.full      (out_full),
		.empty     (empty),
		.level     (out_level)
	);

	// the back end reserves room, so a result never meets a full queue
	a_res_room: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> !out_full)
		else $error("result pushed into full result queue");

	// the front end only forwards words the mid queue can take
	a_mid_room: assert property (@(posedge clk) disable iff (!arst_n)
		mid_push |-> (int'(mid_level) < MID_DEPTH))
		else $error("word pushed into full mid queue");

	// a short word before the last one never reaches the back end
	a_skip: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !full && !in_data.last && !in_data.byte_count[2]) |-> !mid_push)
		else $error("short non-last word forwarded");

endmodule

// ===== tb/sv/weighted_word_checksum_check_top_tb.sv =====
`timescale 1ns / 100ps

module weighted_word_checksum_check_top_tb;
	import wwcc_pkg::*;

	localparam int SETTLE_CYCLES = 24;
	localparam int QUIET_LIMIT = 1000;

	typedef struct packed {
		logic [63:0]      sum;
		logic [IDX_W-1:0] widx;
		logic             fault;
	} cksum_state_t;

	typedef in_t payload_t[$];

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;
	logic [DATA_W-1:0] prdata;
	logic pready;
	logic push = 1'b0;
	logic full;
	in_t in_data = '0;
	logic empty;
	logic pop = 1'b0;
	out_t out_data;

	// predictor copy of the registers and the running checksum
	logic [31:0] cfg_length = TOTAL_LENGTH_RST;
	logic [63:0] cfg_expected = EXPECTED_HASH_RST;
	cksum_state_t run_state = '0;
	out_t due_reports[$];

	int fails = 0;
	int quiet = 0;
	int pop_hold = 0;
	bit calm = 1'b0;

	weighted_word_checksum_check_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.push(push),
		.full(full),
		.in_data(in_data),
		.empty(empty),
		.pop(pop),
		.out_data(out_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// reverse the bytes inside each 32-bit half
	function automatic logic [63:0] half_swap(input logic [63:0] h);
		return {h[39:32], h[47:40], h[55:48], h[63:56], h[7:0], h[15:8], h[23:16], h[31:24]};
	endfunction

	// fold one word into the checksum state; returns 1 when it closes a payload
	function automatic bit fold_word(inout cksum_state_t s, input logic [31:0] len,
			input logic [63:0] want, input in_t w, output out_t r);
		logic [2:0] cnt;
		logic [31:0] t;
		logic [63:0] idx, base, pos, seen;
		cnt = (w.byte_count > 3'd4) ? 3'd4 : w.byte_count;
		r = '0;
		// a short word before the end poisons the payload and adds nothing
		if (!w.last && cnt != 3'd4) begin
			s.fault = 1'b1;
			return 1'b0;
		end
		if (cnt == 3'd4) begin
			t = len / 32'd3 + w.data_word;
			idx = {34'd0, s.widx};
			s.sum += ({32'd0, t} + idx) * (idx + 64'd1);
			if (s.widx == '1)
				s.fault = 1'b1;
			s.widx += 1'b1;
			seen = {32'd0, s.widx, 2'b00};
		end else begin
			base = {32'd0, s.widx, 2'b00};
			for (int k = 0; k < cnt; k++) begin
				t = len / 32'd2 + {24'd0, w.data_word[8*k +: 8]};
				pos = base + k;
				s.sum += ({32'd0, t} + pos) * (pos + 64'd1);
			end
			seen = base + cnt;
		end
		if (!w.last)
			return 1'b0;
		r.hash_value = s.sum;
		r.match = (s.sum == want) || (half_swap(s.sum) == want);
		r.length_error = s.fault || (seen != {32'd0, len});
		s = '0;
		return 1'b1;
	endfunction

	// checksum a whole payload on a scratch state
	function automatic logic [63:0] hash_of(input payload_t p, input logic [31:0] len);
		cksum_state_t s;
		out_t r;
		logic [63:0] h;
		s = '0;
		h = '0;
		foreach (p[i])
			if (fold_word(s, len, 64'd0, p[i], r))
				h = r.hash_value;
		return h;
	endfunction

	// well-formed payload of nbytes random bytes, tail in the last word
	function automatic payload_t build_payload(input int nbytes);
		payload_t p;
		int nwords, tail;
		nwords = nbytes / 4;
		tail = nbytes % 4;
		for (int i = 0; i < nwords; i++)
			p.push_back(in_t'{$urandom, 3'd4, tail == 0 && i == nwords - 1});
		if (tail != 0 || nbytes == 0)
			p.push_back(in_t'{$urandom, 3'(tail), 1'b1});
		return p;
	endfunction

	// offer one word, with an occasional gap, and predict on acceptance
	task automatic send_word(input in_t w);
		out_t r;
		if (!calm && $urandom_range(0, 7) == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
		push <= 1'b1;
		in_data <= w;
		do @(posedge clk); while (full);
		if (fold_word(run_state, cfg_length, cfg_expected, w, r))
			due_reports.push_back(r);
	endtask

	task automatic send_payload(input payload_t p);
		foreach (p[i])
			send_word(p[i]);
	endtask

	// drop push and wait until the block has nothing left in flight
	task automatic settle();
		push <= 1'b0;
		while (due_reports.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// write a register over APB, then read it back
	task automatic write_reg(input logic reg_code, input logic [63:0] value);
		logic [63:0] got;
		settle();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_W'(reg_code) << REG_SEL_BIT;
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (reg_code == REG_TOTAL_LENGTH)
			cfg_length = value[31:0];
		else
			cfg_expected = value;
		pwrite <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		got = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		if (reg_code == REG_TOTAL_LENGTH ? got[31:0] != value[31:0] : got != value) begin
			$display("%0t: readback of register %0d expected %h actual %h",
				$time, reg_code, value, got);
			fails++;
		end
	endtask

	// single bytes under reset settings, then an empty last word
	task automatic test_lone_bytes();
		send_word(in_t'{32'h0000_00FF, 3'd1, 1'b1});
		send_word(in_t'{32'hFFFF_FF00, 3'd0, 1'b1});
	endtask

	// full word arriving as the last one
	task automatic test_word_on_last();
		write_reg(REG_TOTAL_LENGTH, 64'd4);
		send_word(in_t'{32'hFFFF_FFFF, 3'd4, 1'b1});
		send_word(in_t'{32'h0000_0000, 3'd4, 1'b1});
	endtask

	// straight and half-swapped match against the stored checksum
	task automatic test_matching_hash();
		payload_t p;
		logic [63:0] h;
		p = build_payload(15);
		h = hash_of(p, 32'd15);
		write_reg(REG_TOTAL_LENGTH, 64'd15);
		write_reg(REG_EXPECTED_HASH, h);
		send_payload(p);
		write_reg(REG_EXPECTED_HASH, half_swap(h));
		send_payload(p);
	endtask

	// short words before the end, and byte counts above four
	task automatic test_sequence_faults();
		write_reg(REG_TOTAL_LENGTH, 64'd8);
		send_word(in_t'{32'h1234_5678, 3'd2, 1'b0});
		send_word(in_t'{32'h8765_4321, 3'd5, 1'b0});
		send_word(in_t'{32'hA5A5_5A5A, 3'd0, 1'b0});
		send_word(in_t'{32'h0F0F_F0F0, 3'd7, 1'b0});
		send_word(in_t'{32'hDEAD_BEEF, 3'd6, 1'b1});
	endtask

	// length at both ends of its range; word index overflow is out of reach
	task automatic test_length_extremes();
		write_reg(REG_TOTAL_LENGTH, 64'hFFFF_FFFF);
		write_reg(REG_EXPECTED_HASH, 64'hFFFF_FFFF_FFFF_FFFF);
		send_word(in_t'{32'hFFFF_FFFF, 3'd4, 1'b0});
		send_word(in_t'{32'hFFFF_FFFF, 3'd3, 1'b1});
		write_reg(REG_TOTAL_LENGTH, 64'd0);
		send_word(in_t'{32'h0000_0000, 3'd0, 1'b1});
	endtask

	// mostly well-formed payloads, some replaying the stored one, plus noise
	task automatic test_random_phase(input logic [31:0] len, input int items, input bit swapped);
		payload_t golden, p;
		logic [63:0] h;
		int nominal, sent, pick, n;
		nominal = (len <= 32'd48) ? int'(len) : $urandom_range(4, 48);
		golden = build_payload(nominal);
		h = hash_of(golden, len);
		write_reg(REG_TOTAL_LENGTH, {32'd0, len});
		write_reg(REG_EXPECTED_HASH, swapped ? half_swap(h) : h);
		sent = 0;
		while (sent < items) begin
			pick = $urandom_range(0, 99);
			p.delete();
			if (pick < 25)
				p = golden;
			else if (pick < 75)
				p = build_payload(nominal);
			else if (pick < 87)
				p = build_payload($urandom_range(0, 40));
			else begin
				n = $urandom_range(1, 6);
				for (int i = 0; i < n; i++)
					p.push_back(in_t'{$urandom, 3'($urandom_range(0, 7)),
						$urandom_range(0, 3) == 0});
			end
			send_payload(p);
			sent += p.size();
		end
		// close the phase on a clean payload
		send_payload(build_payload(nominal));
	endtask

	// result side stalls in bursts
	always @(posedge clk) begin
		if (calm)
			pop <= 1'b1;
		else if (pop_hold > 0) begin
			pop_hold = pop_hold - 1;
			pop <= 1'b0;
		end else if ($urandom_range(0, 5) == 0) begin
			pop_hold = $urandom_range(1, 9) - 1;
			pop <= 1'b0;
		end else
			pop <= 1'b1;
	end

	// compare each popped result with the oldest prediction
	always @(posedge clk) begin : check_results
		out_t want;
		if (arst_n && pop && !empty) begin
			if (due_reports.size() == 0) begin
				$display("%0t: unexpected result, hash_value expected none actual %h",
					$time, out_data.hash_value);
				fails++;
			end else begin
				want = due_reports.pop_front();
				if (out_data.hash_value !== want.hash_value) begin
					$display("%0t: hash_value expected %h actual %h",
						$time, want.hash_value, out_data.hash_value);
					fails++;
				end
				if (out_data.match !== want.match) begin
					$display("%0t: match expected %b actual %b",
						$time, want.match, out_data.match);
					fails++;
				end
				if (out_data.length_error !== want.length_error) begin
					$display("%0t: length_error expected %b actual %b",
						$time, want.length_error, out_data.length_error);
					fails++;
				end
			end
		end
	end

	// end the run when nothing moves for too long
	always @(posedge clk) begin
		if (!arst_n || psel || (push && !full) || (pop && !empty))
			quiet = 0;
		else
			quiet++;
		if (quiet >= QUIET_LIMIT) begin
			$display("%0t: no word moved for %0d cycles", $time, quiet);
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_lone_bytes();
		test_word_on_last();
		test_matching_hash();
		test_sequence_faults();
		test_length_extremes();
		test_random_phase(32'd12, 100, 1'b0);
		test_random_phase(32'($urandom_range(1, 48)), 100, 1'b1);
		test_random_phase(32'hFFFF_FFFF, 50, 1'b0);
		test_random_phase(32'd1, 70, 1'b1);
		test_random_phase(32'd0, 30, 1'b0);
		settle();
		calm = 1'b1;
		test_random_phase(32'($urandom_range(1, 48)), 130, 1'b0);
		settle();
		if (fails == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
